// ----- rtl/core/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion shorthands for the LRU replacement block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked at every clock, off during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lru_pkg.sv -----
// ============================================================================
// LRU package
// Sizes, types and helpers shared by the frame cells and the top level.
// ============================================================================
`timescale 1ns / 1ps

package lru_pkg;

    // Number of frames and width of a stored page number
    localparam int NUM_FRAMES = 4;
    localparam int PAGE_BITS  = 16;

    // Fixed widths of the request and result fields
    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 4;
    localparam int COUNT_W     = 32;

    // Derived widths
    localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // What the update pass does this transaction
    typedef enum logic [1:0] {
        CMD_HIT,
        CMD_FILL,
        CMD_EVICT
    } lru_kind_t;

    typedef struct packed {
        lru_kind_t kind;
        idx_t      target;
        rank_t     ref_rank;
        rank_t     new_rank;
    } lru_cmd_t;

    // Lookup summary handed from cell to cell
    typedef struct packed {
        logic  found;
        idx_t  found_idx;
        rank_t found_rank;
        logic  empty_found;
        idx_t  empty_idx;
        cnt_t  count;
        logic  victim_found;
        idx_t  victim_idx;
        page_t victim_page;
    } lru_chain_t;

    // Per-cell status for checking
    typedef struct packed {
        logic valid;
        logic match;
    } lru_cell_stat_t;

    // Request page to stored page width (truncate or zero-extend)
    function automatic page_t to_page(logic [PAGE_IN_W-1:0] p);
        logic [2*32-1:0] w;
        w = '0;
        w[PAGE_IN_W-1:0] = p;
        return w[PAGE_BITS-1:0];
    endfunction

    // Stored page back to result width
    function automatic logic [PAGE_IN_W-1:0] from_page(page_t p);
        logic [2*32-1:0] w;
        w = '0;
        w[PAGE_BITS-1:0] = p;
        return w[PAGE_IN_W-1:0];
    endfunction

endpackage

// ----- rtl/core/lru_cell.sv -----
// ============================================================================
// LRU frame cell
// Holds one frame (page, valid, rank), extends the lookup chain, and applies
// the broadcast update on an accepted transaction.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_cell
    import lru_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  idx_t           cell_idx,
    input  page_t          key,
    input  logic           update,
    input  lru_cmd_t       cmd,
    input  lru_chain_t     chain_in,
    output lru_chain_t     chain_out,
    output lru_cell_stat_t stat
);

    page_t page_reg;
    logic  valid_reg;
    rank_t rank_reg;

    logic  match;
    logic  is_target;

    assign match     = valid_reg && (page_reg == key);
    assign is_target = (cmd.target == cell_idx);

    assign stat.valid = valid_reg;
    assign stat.match = match;

    // Extend the lookup chain: first match, first empty, count, first rank-0
    always_comb
    begin
        chain_out       = chain_in;
        chain_out.count = chain_in.count + CNT_W'(valid_reg);
        if (!chain_in.found && match)
        begin
            chain_out.found      = 1'b1;
            chain_out.found_idx  = cell_idx;
            chain_out.found_rank = rank_reg;
        end
        if (!chain_in.empty_found && !valid_reg)
        begin
            chain_out.empty_found = 1'b1;
            chain_out.empty_idx   = cell_idx;
        end
        if (!chain_in.victim_found && valid_reg && (rank_reg == '0))
        begin
            chain_out.victim_found = 1'b1;
            chain_out.victim_idx   = cell_idx;
            chain_out.victim_page  = page_reg;
        end
    end

    // Valid and recency update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (update)
        begin
            unique case (cmd.kind)
                CMD_HIT:
                begin
                    if (is_target)
                        rank_reg <= cmd.new_rank;
                    else if (valid_reg && (rank_reg > cmd.ref_rank))
                        rank_reg <= rank_reg - RANK_W'(1);
                end
                CMD_FILL:
                begin
                    if (is_target)
                    begin
                        valid_reg <= 1'b1;
                        rank_reg  <= cmd.new_rank;
                    end
                end
                CMD_EVICT:
                begin
                    if (is_target)
                        rank_reg <= cmd.new_rank;
                    else if (rank_reg != '0)
                        rank_reg <= rank_reg - RANK_W'(1);
                end
                default:
                begin
                    rank_reg <= rank_reg;
                end
            endcase
        end
    end

    // Page storage, written on fill or eviction of this frame
    always_ff @(posedge clk)
    begin
        if (update && is_target && (cmd.kind != CMD_HIT))
            page_reg <= key;
    end

    // An empty frame always sits at rank zero
    `ASSERT_CLK(a_empty_rank_zero, (!valid_reg) |-> (rank_reg == '0),
        "empty frame holds a nonzero rank")

endmodule

// ----- rtl/core/lru_page_replacement.sv -----
// ============================================================================
// LRU page replacement
// Fully associative set of NUM_FRAMES frames with LRU replacement, built as a
// chain of frame cells, plus saturating hit and fault counters.
// ============================================================================
//
//  Channel   Handshake             Payload
//  --------  --------------------  ----------------------------------------
//  request   in_valid / in_ready   page_number
//  result    out_valid / out_ready hit, frame_index, evicted_valid,
//                                  evicted_page, hit_count, fault_count
//
//  One request per cycle while in_ready is high: lookup through the cell
//  chain and the frame update both finish in the accepting cycle; the
//  result shows in the next cycle from the output register.
//  in_ready = !out_valid || out_ready, so a held result stalls input only
//  while it waits.
//  Reset (rst_n low) empties all frames and clears both counters.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_page_replacement
    import lru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PAGE_IN_W-1:0]   page_number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic [FRAME_OUT_W-1:0] frame_index,
    output logic                   evicted_valid,
    output logic [PAGE_IN_W-1:0]   evicted_page,
    output logic [COUNT_W-1:0]     hit_count,
    output logic [COUNT_W-1:0]     fault_count
);

    page_t          key;
    logic           accept;
    lru_chain_t     chain [NUM_FRAMES+1];
    lru_cell_stat_t stat  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] match_vec;
    logic [NUM_FRAMES-1:0] valid_vec;
    lru_chain_t     last;
    lru_cmd_t       cmd;

    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [FRAME_OUT_W-1:0] frame_index_reg;
    logic                   evicted_valid_reg;
    logic [PAGE_IN_W-1:0]   evicted_page_reg;
    logic [COUNT_W-1:0]     hits_reg;
    logic [COUNT_W-1:0]     faults_reg;

    assign key      = to_page(page_number);
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Frame cell chain
    assign chain[0] = '0;

    for (genvar g = 0; g < NUM_FRAMES; g++)
    begin : g_cell
        lru_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(g)),
            .key       (key),
            .update    (accept),
            .cmd       (cmd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g])
        );
        assign match_vec[g] = stat[g].match;
        assign valid_vec[g] = stat[g].valid;
    end

    assign last = chain[NUM_FRAMES];

    // Decide hit, fill of first empty frame, or eviction of rank-0 frame
    always_comb
    begin
        cmd.ref_rank = last.found_rank;
        priority if (last.found)
        begin
            cmd.kind     = CMD_HIT;
            cmd.target   = last.found_idx;
            cmd.new_rank = RANK_W'(last.count - CNT_W'(1));
        end
        else if (last.empty_found)
        begin
            cmd.kind     = CMD_FILL;
            cmd.target   = last.empty_idx;
            cmd.new_rank = RANK_W'(last.count);
        end
        else
        begin
            cmd.kind     = CMD_EVICT;
            cmd.target   = last.victim_idx;
            cmd.new_rank = RANK_W'(NUM_FRAMES - 1);
        end
    end

    // Saturating counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg   <= '0;
            faults_reg <= '0;
        end
        else if (accept)
        begin
            if (cmd.kind == CMD_HIT)
            begin
                if (hits_reg != '1)
                    hits_reg <= hits_reg + COUNT_W'(1);
            end
            else if (faults_reg != '1)
            begin
                faults_reg <= faults_reg + COUNT_W'(1);
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg           <= (cmd.kind == CMD_HIT);
            frame_index_reg   <= FRAME_OUT_W'(cmd.target);
            evicted_valid_reg <= (cmd.kind == CMD_EVICT);
            evicted_page_reg  <= (cmd.kind == CMD_EVICT) ? from_page(last.victim_page)
                                                         : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    // Counters change only on the edge that replaces the held result
    assign hit_count     = hits_reg;
    assign fault_count   = faults_reg;

    // A page never sits in two frames
    `ASSERT_CLK(a_single_match, $onehot0(match_vec), "page resident in several frames")

    // Eviction only when every frame is full
    `ASSERT_CLK(a_evict_when_full, (accept && (cmd.kind == CMD_EVICT)) |-> (&valid_vec),
        "eviction with an empty frame present")

    // A full frame set always offers a rank-0 victim
    `ASSERT_CLK(a_victim_present, (accept && (cmd.kind == CMD_EVICT)) |-> last.victim_found,
        "no rank-zero frame to evict")

    // A hit bumps the hit counter unless saturated
    `ASSERT_NEXT(a_hit_counts, (accept && (cmd.kind == CMD_HIT)),
        (hits_reg == $past(hits_reg) + COUNT_W'(1)) || ($past(hits_reg) == '1),
        "hit counter did not advance")

    // A reported eviction is never a hit
    `ASSERT_CLK(a_evict_not_hit, (out_valid_reg && evicted_valid_reg) |-> (!hit_reg),
        "result flags both hit and eviction")

endmodule
